>>> sv/iar_pkg.sv
// Shared types, constants and helpers for the integer to ASCII converter.
`default_nettype none

package iar_pkg;

    localparam int unsigned VAL_W      = 64;
    localparam int unsigned BCD_W      = 80;
    localparam int unsigned CNT_W      = 7;
    localparam int unsigned DEC_DIGITS = 20;
    localparam int unsigned HEX_DIGITS = 16;
    localparam int unsigned BIN_DIGITS = 64;
    localparam int unsigned Q_DEPTH    = 2;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_F    = 8'h46;
    localparam logic [3:0] DEC_BASE  = 4'd10;

    localparam logic [1:0] CODE_BIN  = 2'd0;
    localparam logic [1:0] CODE_DEC  = 2'd1;
    localparam logic [1:0] CODE_HEX  = 2'd2;
    localparam logic [1:0] CODE_RSVD = 2'd3;

    typedef enum logic [1:0] {
        RADIX_BIN,
        RADIX_DEC,
        RADIX_HEX
    } t_radix;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0] mag;
        t_radix           radix;
        logic             neg;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
        logic [7:0] ch;
        if (d < DEC_BASE) begin
            ch = CHAR_ZERO + {4'd0, d};
        end else begin
            ch = CHAR_A + {4'd0, d - DEC_BASE};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> sv/iar_front.sv
// Front end: accepts a value, derives sign, magnitude and radix.
`default_nettype none

module iar_front (
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [63:0]                i_value,
    input  wire logic                       i_is_unsigned,
    input  wire logic                       i_is_long,
    input  wire logic [1:0]                 i_base_code,
    input  wire iar_pkg::t_q_stat           i_q_stat,
    output logic                            o_push,
    output iar_pkg::t_job                   o_job
);
    import iar_pkg::*;

    logic [VAL_W-1:0] w_val;
    logic [VAL_W-1:0] w_neg64;
    logic [31:0]      w_neg32;

    assign w_val   = i_is_long ? i_value : {32'd0, i_value[31:0]};
    assign w_neg64 = '0 - w_val;
    assign w_neg32 = 32'd0 - w_val[31:0];

    always_comb begin
        o_job.neg = 1'b0;
        o_job.mag = w_val;
        if (!i_is_unsigned) begin
            if (i_is_long) begin
                o_job.neg = w_val[VAL_W-1];
                o_job.mag = w_val[VAL_W-1] ? w_neg64 : w_val;
            end else begin
                o_job.neg = w_val[31];
                o_job.mag = w_val[31] ? {32'd0, w_neg32} : w_val;
            end
        end
        unique case (i_base_code)
            CODE_BIN: o_job.radix = RADIX_BIN;
            CODE_DEC: o_job.radix = RADIX_DEC;
            default:  o_job.radix = RADIX_HEX;
        endcase
    end

    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

endmodule

`default_nettype wire

>>> sv/iar_fifo.sv
// Two-entry job queue between front end and digit generator.
`default_nettype none

module iar_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire iar_pkg::t_job    i_job,
    input  wire logic             i_pop,
    output iar_pkg::t_job         o_job,
    output logic                  o_valid,
    output iar_pkg::t_q_stat      o_stat
);
    import iar_pkg::*;

    t_job       r_mem [Q_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rd_ptr];
    assign o_valid      = (r_count != 2'd0);
    assign o_stat.full  = (r_count == 2'(Q_DEPTH));
    assign o_stat.empty = (r_count == 2'd0);

endmodule

`default_nettype wire

>>> sv/iar_back.sv
// Back end: binary to BCD conversion for decimal jobs and most-significant-first digit output.
`default_nettype none

module iar_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire iar_pkg::t_job    i_job,
    input  wire logic             i_job_valid,
    output logic                  o_job_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [7:0]            o_char_code,
    output logic                  o_minus_first,
    output logic                  o_last_char
);
    import iar_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [BCD_W-1:0] r_dig;
    logic [BCD_W-1:0] n_dig;
    logic [VAL_W-1:0] r_bin;
    logic [VAL_W-1:0] n_bin;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_started;
    logic             n_started;
    logic             r_neg;
    logic             n_neg;
    t_radix           r_rad;
    t_radix           n_rad;
    logic             r_ov;
    logic             n_ov;
    logic [7:0]       r_char;
    logic [7:0]       n_char;
    logic             r_minus;
    logic             n_minus;
    logic             r_last;
    logic             n_last;

    logic [BCD_W-1:0] w_adj;
    logic [3:0]       w_top;
    logic             w_adv;
    logic             w_emit;

    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            w_adj[i*4 +: 4] = (r_dig[i*4 +: 4] >= 4'd5) ? r_dig[i*4 +: 4] + 4'd3
                                                          : r_dig[i*4 +: 4];
        end
    end

    assign w_top  = (r_rad == RADIX_BIN) ? {3'd0, r_dig[BCD_W-1]} : r_dig[BCD_W-1 -: 4];
    assign w_adv  = !r_ov || i_out_ready;
    assign w_emit = (w_top != 4'd0) || r_started || (r_cnt == CNT_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.radix == RADIX_DEC) ? ST_CONV : ST_EMIT;
                end
            end
            ST_CONV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_adv && r_cnt == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_dig     = r_dig;
        n_bin     = r_bin;
        n_cnt     = r_cnt;
        n_started = r_started;
        n_neg     = r_neg;
        n_rad     = r_rad;
        n_ov      = r_ov && !i_out_ready;
        n_char    = r_char;
        n_minus   = r_minus;
        n_last    = r_last;
        o_job_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_job_pop = i_job_valid;
                if (i_job_valid) begin
                    n_neg     = i_job.neg;
                    n_rad     = i_job.radix;
                    n_started = 1'b0;
                    if (i_job.radix == RADIX_DEC) begin
                        n_bin = i_job.mag;
                        n_dig = '0;
                        n_cnt = CNT_W'(BIN_DIGITS);
                    end else begin
                        n_dig = {i_job.mag, 16'd0};
                        n_cnt = (i_job.radix == RADIX_BIN) ? CNT_W'(BIN_DIGITS)
                                                           : CNT_W'(HEX_DIGITS);
                    end
                end
            end
            ST_CONV: begin
                n_dig = {w_adj[BCD_W-2:0], r_bin[VAL_W-1]};
                n_bin = {r_bin[VAL_W-2:0], 1'b0};
                n_cnt = (r_cnt == CNT_W'(1)) ? CNT_W'(DEC_DIGITS) : r_cnt - CNT_W'(1);
            end
            ST_EMIT: begin
                if (w_adv) begin
                    n_dig = (r_rad == RADIX_BIN) ? {r_dig[BCD_W-2:0], 1'b0}
                                                 : {r_dig[BCD_W-5:0], 4'd0};
                    n_cnt = r_cnt - CNT_W'(1);
                    if (w_emit) begin
                        n_ov      = 1'b1;
                        n_char    = digit_to_ascii(w_top);
                        n_minus   = r_neg && !r_started;
                        n_last    = (r_cnt == CNT_W'(1));
                        n_started = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig     <= n_dig;
        r_bin     <= n_bin;
        r_cnt     <= n_cnt;
        r_started <= n_started;
        r_neg     <= n_neg;
        r_rad     <= n_rad;
        r_char    <= n_char;
        r_minus   <= n_minus;
        r_last    <= n_last;
    end

    assign o_out_valid   = r_ov;
    assign o_char_code   = r_char;
    assign o_minus_first = r_minus;
    assign o_last_char   = r_last;

endmodule

`default_nettype wire

>>> sv/int_to_ascii_radix.sv
// Top level: integer to ASCII digit converter for base 2, 10 and 16.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_value, i_is_unsigned, i_is_long, i_base_code
//  out     | output    | o_out_valid / i_out_ready | o_char_code, o_minus_first, o_last_char
//
// One transaction in yields 1 to 64 digit transactions out, most significant first.
// A decimal item goes through one load, 64 double-dabble shifts in the BCD converter
// and 20 digit slots; hex and binary items go from the load straight to their digit slots.
// The front end keeps taking items into a two-entry queue while the back end works.
// A stalled output holds the digit generator; reset is synchronous, active low.
`default_nettype none

module int_to_ascii_radix (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_value,
    input  wire logic        i_is_unsigned,
    input  wire logic        i_is_long,
    input  wire logic [1:0]  i_base_code,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_char_code,
    output logic             o_minus_first,
    output logic             o_last_char
);
    import iar_pkg::*;

    t_job    w_push_job;
    t_job    w_pop_job;
    logic    w_push;
    logic    w_pop;
    logic    w_q_valid;
    t_q_stat w_q_stat;

    iar_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_value       (i_value),
        .i_is_unsigned (i_is_unsigned),
        .i_is_long     (i_is_long),
        .i_base_code   (i_base_code),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    iar_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_valid (w_q_valid),
        .o_stat  (w_q_stat)
    );

    iar_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (w_pop_job),
        .i_job_valid   (w_q_valid),
        .o_job_pop     (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_char_code   (o_char_code),
        .o_minus_first (o_minus_first),
        .o_last_char   (o_last_char)
    );

    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue reports full and empty together");

    a_no_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_minus_first) |-> (o_char_code != CHAR_ZERO))
        else $error("negative run starts with a zero digit");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_char_code >= CHAR_ZERO && o_char_code <= CHAR_NINE) ||
                         (o_char_code >= CHAR_A && o_char_code <= CHAR_F)))
        else $error("digit outside 0-9 and A-F");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for int_to_ascii_radix: queued driver, stalling sink and digit predictor.
module tb_top;
    import iar_pkg::*;

    localparam int unsigned HALF_PERIOD = 6;
    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned TIMEOUT = 7_200_000;
    localparam int unsigned MAX_REPORTS = 10;

    localparam int PH_STEADY = 0;
    localparam int PH_SRC_IDLE = 1;
    localparam int PH_SNK_STALL = 2;
    localparam int PH_BOTH = 3;

    typedef struct {
        logic [63:0] value;
        logic        uns;
        logic        lng;
        logic [1:0]  code;
        int          phase;
        logic        hold;
    } t_conv_req;

    typedef struct {
        logic [7:0] ch;
        logic       minus;
        logic       last;
    } t_digit;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [63:0] in_value = '0;
    logic        in_unsigned = 1'b0;
    logic        in_long = 1'b0;
    logic [1:0]  in_code = '0;
    logic        out_ready = 1'b0;
    logic        hold_req = 1'b0;
    int          rx_phase = PH_STEADY;
    int unsigned hold_cnt = 0;

    wire logic       o_in_ready;
    wire logic       o_out_valid;
    wire logic [7:0] o_char_code;
    wire logic       o_minus_first;
    wire logic       o_last_char;

    t_conv_req   req_q[$];
    t_digit      digits_due[$];
    int unsigned err_cnt = 0;

    int_to_ascii_radix dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_value       (in_value),
        .i_is_unsigned (in_unsigned),
        .i_is_long     (in_long),
        .i_base_code   (in_code),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_char_code   (o_char_code),
        .o_minus_first (o_minus_first),
        .o_last_char   (o_last_char)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    function automatic void predict_digits(input logic [63:0] value, input logic uns,
                                           input logic lng, input logic [1:0] code);
        logic [63:0] v;
        logic [63:0] mag;
        logic [63:0] radix;
        logic [3:0]  rev[64];
        logic        neg;
        logic [3:0]  d;
        int          n;
        t_digit      dg;
        n = 0;
        neg = 1'b0;
        if (code == CODE_BIN) begin
            radix = 64'd2;
        end else if (code == CODE_DEC) begin
            radix = 64'd10;
        end else begin
            radix = 64'd16;
        end
        v = lng ? value : {32'd0, value[31:0]};
        if (uns) begin
            mag = v;
        end else if (lng) begin
            neg = v[63];
            mag = neg ? (64'd0 - v) : v;
        end else begin
            neg = v[31];
            mag = neg ? {32'd0, 32'd0 - v[31:0]} : v;
        end
        if (mag == 64'd0) begin
            rev[0] = 4'd0;
            n = 1;
        end
        while (mag != 64'd0 && n < 64) begin
            rev[n] = 4'(mag % radix);
            mag = mag / radix;
            n++;
        end
        for (int k = 0; k < n; k++) begin
            d = rev[n - 1 - k];
            dg.ch = (d < DEC_BASE) ? (CHAR_ZERO + 8'(d)) : (CHAR_A + 8'(d - DEC_BASE));
            dg.minus = (k == 0) && neg;
            dg.last = (k == n - 1);
            digits_due.push_back(dg);
        end
    endfunction

    function automatic logic src_idles(input int phase);
        if (phase == PH_SRC_IDLE) begin
            return $urandom_range(0, 99) < 54;
        end else if (phase == PH_BOTH) begin
            return $urandom_range(0, 99) < 7;
        end
        return 1'b0;
    endfunction

    function automatic logic snk_stalls(input int phase);
        if (phase == PH_SNK_STALL) begin
            return $urandom_range(0, 99) < 54;
        end else if (phase == PH_BOTH) begin
            return $urandom_range(0, 99) < 7;
        end
        return 1'b0;
    endfunction

    task automatic add_req(input logic [63:0] value, input logic uns, input logic lng,
                           input logic [1:0] code, input int phase, input logic hold);
        t_conv_req r;
        r.value = value;
        r.uns = uns;
        r.lng = lng;
        r.code = code;
        r.phase = phase;
        r.hold = hold;
        req_q.push_back(r);
    endtask

    task automatic add_random(input int phase, input int cnt);
        logic [63:0] v;
        for (int i = 0; i < cnt; i++) begin
            case ($urandom_range(0, 5))
                0: v = {$urandom, $urandom};
                1: v = 64'($urandom_range(0, 20));
                2: begin
                    case ($urandom_range(0, 7))
                        0: v = 64'd0;
                        1: v = 64'd1;
                        2: v = 64'h7FFF_FFFF_FFFF_FFFF;
                        3: v = 64'h8000_0000_0000_0000;
                        4: v = 64'hFFFF_FFFF_FFFF_FFFF;
                        5: v = 64'h0000_0000_7FFF_FFFF;
                        6: v = {$urandom, 32'h8000_0000};
                        default: v = 64'h0000_0000_FFFF_FFFF;
                    endcase
                end
                3: v = 64'd0 - 64'($urandom_range(1, 1000));
                4: v = 64'd1 << $urandom_range(0, 63);
                default: v = {$urandom, 32'($urandom_range(0, 99999))};
            endcase
            add_req(v, 1'($urandom), 1'($urandom), 2'($urandom_range(0, 3)), phase, 1'b0);
        end
    endtask

    // Driver: offer queued transactions, predict on acceptance.
    always @(posedge i_clk) begin
        t_conv_req nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            hold_req <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_digits(in_value, in_unsigned, in_long, in_code);
            end
            if (!in_valid || o_in_ready) begin
                if (req_q.size() != 0 && !src_idles(req_q[0].phase)) begin
                    nxt = req_q.pop_front();
                    in_value <= nxt.value;
                    in_unsigned <= nxt.uns;
                    in_long <= nxt.lng;
                    in_code <= nxt.code;
                    in_valid <= 1'b1;
                    rx_phase <= nxt.phase;
                    hold_req <= nxt.hold;
                end else begin
                    in_valid <= 1'b0;
                    hold_req <= 1'b0;
                end
            end else begin
                hold_req <= 1'b0;
            end
        end
    end

    // Sink: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_req) begin
            out_ready <= 1'b0;
            hold_cnt <= HOLD_CYCLES;
        end else if (hold_cnt != 0) begin
            out_ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else begin
            out_ready <= !snk_stalls(rx_phase);
        end
    end

    // Monitor: compare each digit transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_digit exp_d;
        if (rst_n && o_out_valid && out_ready) begin
            if (digits_due.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS) begin
                    $display("unexpected digit: ch=%h minus=%b last=%b",
                             o_char_code, o_minus_first, o_last_char);
                end
            end else begin
                exp_d = digits_due.pop_front();
                if (o_char_code !== exp_d.ch || o_minus_first !== exp_d.minus ||
                    o_last_char !== exp_d.last) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display({"digit mismatch: exp ch=%h minus=%b last=%b,",
                                  " got ch=%h minus=%b last=%b"},
                                 exp_d.ch, exp_d.minus, exp_d.last,
                                 o_char_code, o_minus_first, o_last_char);
                    end
                end
            end
        end
    end

    initial begin
        #TIMEOUT;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        add_req(64'd0, 1'b0, 1'b0, CODE_BIN, PH_STEADY, 1'b0);
        add_req(64'd0, 1'b1, 1'b1, CODE_DEC, PH_STEADY, 1'b0);
        add_req(64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0, CODE_HEX, PH_STEADY, 1'b0);
        add_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, CODE_BIN, PH_STEADY, 1'b0);
        add_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, CODE_DEC, PH_STEADY, 1'b0);
        add_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, CODE_HEX, PH_STEADY, 1'b0);
        add_req(64'h8000_0000_0000_0000, 1'b0, 1'b1, CODE_BIN, PH_STEADY, 1'b0);
        add_req(64'h8000_0000_0000_0000, 1'b0, 1'b1, CODE_DEC, PH_STEADY, 1'b0);
        add_req(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, CODE_DEC, PH_STEADY, 1'b0);
        add_req(64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0, CODE_DEC, PH_STEADY, 1'b0);
        add_req(64'h0000_0000_8000_0000, 1'b0, 1'b0, CODE_HEX, PH_STEADY, 1'b0);
        add_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, CODE_DEC, PH_STEADY, 1'b0);
        add_req(64'h1234_5678_FFFF_FFFF, 1'b0, 1'b0, CODE_HEX, PH_STEADY, 1'b0);
        add_req(64'hA5A5_A5A5_FFFF_FFFF, 1'b1, 1'b0, CODE_DEC, PH_STEADY, 1'b0);
        add_req(64'h5A5A_5A5A_8000_0000, 1'b0, 1'b0, CODE_BIN, PH_STEADY, 1'b0);
        add_req(64'h0000_0000_00AB_CDEF, 1'b1, 1'b0, CODE_HEX, PH_STEADY, 1'b0);
        add_req(64'h0000_0000_00AB_CDEF, 1'b1, 1'b0, CODE_RSVD, PH_STEADY, 1'b0);
        add_req(64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, CODE_HEX, PH_STEADY, 1'b0);
        add_req(64'd1, 1'b0, 1'b1, CODE_BIN, PH_STEADY, 1'b0);
        add_req(64'd9, 1'b1, 1'b0, CODE_DEC, PH_STEADY, 1'b0);
        add_req(64'd10, 1'b0, 1'b0, CODE_DEC, PH_STEADY, 1'b0);
        add_req(64'd15, 1'b1, 1'b1, CODE_HEX, PH_STEADY, 1'b0);
        add_req(64'd16, 1'b0, 1'b1, CODE_RSVD, PH_STEADY, 1'b0);
        add_random(PH_STEADY, 50);
        add_random(PH_SRC_IDLE, 70);
        add_random(PH_SNK_STALL, 70);
        add_random(PH_BOTH, 70);
        add_req({$urandom, $urandom}, 1'b1, 1'b1, CODE_BIN, PH_STEADY, 1'b1);
        add_random(PH_STEADY, 15);
        add_random(PH_BOTH, 20);

        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;

        while (req_q.size() != 0 || in_valid || digits_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (digits_due.size() != 0) begin
            err_cnt++;
            $display("digits never produced: %0d", digits_due.size());
        end
        if (err_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/iar_pkg.sv
sv/iar_front.sv
sv/iar_fifo.sv
sv/iar_back.sv
sv/int_to_ascii_radix.sv
tb/sv/tb_top.sv
